[rtl/sdspi_pkg.sv]
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types, phase codes and constants shared by the SD SPI host sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned BlockBytes   = 512;
  localparam int unsigned IdleBytes    = 23;
  localparam int unsigned ResetRounds  = 3;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_PWR    = 4'd1,
    PH_CMD    = 4'd2,
    PH_R1     = 4'd3,
    PH_R7     = 4'd4,
    PH_OCR    = 4'd5,
    PH_TOKEN  = 4'd6,
    PH_RDATA  = 4'd7,
    PH_RCRC   = 4'd8,
    PH_WTOKEN = 4'd9,
    PH_WWANT  = 4'd10,
    PH_WDATA  = 4'd11,
    PH_DRESP  = 4'd12,
    PH_BUSY   = 4'd13,
    PH_R2TAIL = 4'd14
  } phase_e;

  typedef enum logic [2:0] {
    REQ_INIT  = 3'd0,
    REQ_READ  = 3'd1,
    REQ_WRITE = 3'd2,
    REQ_RXB   = 3'd3,
    REQ_WDATA = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TIMEOUT  = 3'd1,
    ERR_V1       = 3'd2,
    ERR_BAD_R7   = 3'd3,
    ERR_INIT_TO  = 3'd4,
    ERR_STD_CAP  = 3'd5,
    ERR_WREJECT  = 3'd6
  } err_e;

  localparam logic [5:0] CMD0  = 6'd0;
  localparam logic [5:0] CMD8  = 6'd8;
  localparam logic [5:0] CMD13 = 6'd13;
  localparam logic [5:0] CMD17 = 6'd17;
  localparam logic [5:0] CMD24 = 6'd24;
  localparam logic [5:0] CMD41 = 6'd41;
  localparam logic [5:0] CMD55 = 6'd55;
  localparam logic [5:0] CMD58 = 6'd58;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] block_index;
    logic [7:0]  byte_value;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select_active;
    logic       want_write_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_last;
    logic       done_res;
    logic       error;
    logic [2:0] error_code;
    logic       busy_res;
  } res_t;

  // Sequencer state carried from one word to the next
  typedef struct packed {
    phase_e      phase;
    logic [9:0]  byte_count;
    logic [15:0] retry_count;
    logic [15:0] acmd_count;
    logic [31:0] response_word;
    logic [1:0]  power_round;
    logic [47:0] command_frame;
  } seq_t;

endpackage

[rtl/sdspi_req_if.sv]
// ----------------------------------------------------------------------------
// sdspi_req_if
// Request channel: valid/ready handshake with request word payload.
// ----------------------------------------------------------------------------
interface sdspi_req_if;
  import sdspi_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/sdspi_res_if.sv]
// ----------------------------------------------------------------------------
// sdspi_res_if
// Result channel: valid/ready handshake with result word payload.
// ----------------------------------------------------------------------------
interface sdspi_res_if;
  import sdspi_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/sd_spi_host_sequencer.sv]
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer
// SD card SPI-mode host: init, block read and block write, one result word
// per request word.
//
//   channel   dir  payload
//   req       in   req_type, block_index, byte_value
//   res       out  tx_valid .. busy_res
//   cfg       in   max_retries (write only)
//
// Each request word is decided combinationally; its result sits in the output
// register the next cycle. A new word is taken every cycle while the output
// register is empty or being drained, so throughput is one word a cycle.
// Reset returns the sequencer to idle with max_retries at 0xFFFF.
// A stalled result holds the input side; nothing is dropped.
// ----------------------------------------------------------------------------
module sd_spi_host_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdspi_req_if.sink   req,
  sdspi_res_if.source res,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import sdspi_pkg::*;

  seq_t        st_q, st_d;
  res_t        res_q, res_d;
  logic        vld_q;
  logic [15:0] max_retries_q;
  logic        take;

  assign req.ready = !vld_q || res.ready;
  assign take = req.valid && req.ready;

  sdspi_step u_step (
    .st_i          (st_q),
    .req_i         (req.data),
    .max_retries_i (max_retries_q),
    .st_o          (st_d),
    .res_o         (res_d)
  );

  // Hold the retry limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_retries_q <= 16'hFFFF;
    else if (cfg_we_i) max_retries_q <= cfg_wdata_i;
  end

  // Advance the state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, default: '0};
      vld_q <= 1'b0;
    end else begin
      if (take) st_q <= st_d;
      if (take) vld_q <= 1'b1;
      else if (res.ready) vld_q <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign res.valid = vld_q;
  assign res.data = res_q;

`ifndef SYNTHESIS
  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (res_d.error || res_d.done_res) |=> st_q.phase == PH_IDLE)
    else $error("finish did not return to idle");
  a_busy_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> res_q.busy_res == (st_q.phase != PH_IDLE))
    else $error("busy flag out of step with phase");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(st_q))
    else $error("state moved without a word");
`endif

endmodule

[rtl/sdspi_step.sv]
// ----------------------------------------------------------------------------
// sdspi_step
// Next-state and result logic for one request word.
// ----------------------------------------------------------------------------
module sdspi_step (
  input  sdspi_pkg::seq_t st_i,
  input  sdspi_pkg::req_t req_i,
  input  logic [15:0]     max_retries_i,
  output sdspi_pkg::seq_t st_o,
  output sdspi_pkg::res_t res_o
);
  import sdspi_pkg::*;

  always_comb begin
    seq_t        s;
    res_t        r;
    logic [7:0]  v;
    logic [9:0]  bc;
    logic [15:0] rc;
    logic [15:0] ac;
    logic [31:0] rw;
    logic [1:0]  pr;
    logic [5:0]  idx;
    logic [5:0]  ncmd;
    logic [31:0] narg;
    logic [7:0]  ncrc;
    logic        do_cmd;
    logic [2:0]  fcode;
    logic        fin;

    s = st_i;
    r = '0;
    r.tx_byte = 8'hFF;
    v = req_i.byte_value;
    do_cmd = 1'b0;
    ncmd = CMD0;
    narg = '0;
    ncrc = 8'h01;
    fin = 1'b0;
    fcode = ERR_NONE;
    bc = st_i.byte_count + 10'd1;
    rc = st_i.retry_count + 16'd1;
    ac = st_i.acmd_count + 16'd1;
    rw = {st_i.response_word[23:0], v};
    pr = st_i.power_round + 2'd1;
    idx = st_i.command_frame[45:40];

    if (st_i.phase == PH_IDLE) begin
      if (req_i.req_type == REQ_INIT) begin
        s.power_round = '0;
        s.byte_count = '0;
        s.phase = PH_PWR;
        r.tx_valid = 1'b1;
      end else if (req_i.req_type == REQ_READ || req_i.req_type == REQ_WRITE) begin
        do_cmd = 1'b1;
        ncmd = (req_i.req_type == REQ_READ) ? CMD17 : CMD24;
        narg = req_i.block_index;
      end
    end else if (req_i.req_type == REQ_RXB && st_i.phase != PH_WWANT) begin
      case (st_i.phase)
        PH_PWR: begin
          s.byte_count = bc;
          if (bc < 10'(IdleBytes)) r.tx_valid = 1'b1;
          else begin
            do_cmd = 1'b1; ncmd = CMD0; ncrc = 8'h95;
          end
        end
        PH_CMD: begin
          s.byte_count = bc;
          if (bc < 10'd6) begin
            r.tx_valid = 1'b1;
            case (bc[2:0])
              3'd1:    r.tx_byte = st_i.command_frame[39:32];
              3'd2:    r.tx_byte = st_i.command_frame[31:24];
              3'd3:    r.tx_byte = st_i.command_frame[23:16];
              3'd4:    r.tx_byte = st_i.command_frame[15:8];
              default: r.tx_byte = st_i.command_frame[7:0];
            endcase
          end else begin
            s.phase = PH_R1; s.retry_count = '0; r.tx_valid = 1'b1;
          end
        end
        PH_R1: begin
          if (v[7]) begin
            s.retry_count = rc;
            if (rc >= max_retries_i) begin fin = 1'b1; fcode = ERR_TIMEOUT; end
            else r.tx_valid = 1'b1;
          end else begin
            case (idx)
              CMD0: begin
                s.power_round = pr;
                if (pr < 2'(ResetRounds)) begin
                  s.phase = PH_PWR; s.byte_count = '0; r.tx_valid = 1'b1;
                end else begin
                  do_cmd = 1'b1; ncmd = CMD8; narg = 32'h1AA; ncrc = 8'h87;
                end
              end
              CMD8: begin
                if (v[2]) begin fin = 1'b1; fcode = ERR_V1; end
                else begin
                  s.phase = PH_R7; s.byte_count = '0; s.response_word = '0;
                  r.tx_valid = 1'b1;
                end
              end
              CMD55: begin
                do_cmd = 1'b1; ncmd = CMD41; narg = 32'h4000_0000;
              end
              CMD41: begin
                s.acmd_count = ac;
                if (v[0]) begin
                  if (ac >= max_retries_i) begin fin = 1'b1; fcode = ERR_INIT_TO; end
                  else begin do_cmd = 1'b1; ncmd = CMD55; end
                end else begin
                  do_cmd = 1'b1; ncmd = CMD58;
                end
              end
              CMD58: begin
                s.phase = PH_OCR; s.byte_count = '0; s.response_word = '0;
                r.tx_valid = 1'b1;
              end
              CMD17: begin
                s.phase = PH_TOKEN; s.retry_count = '0; r.tx_valid = 1'b1;
              end
              CMD24: begin
                s.phase = PH_WTOKEN; r.tx_valid = 1'b1; r.tx_byte = 8'hFE;
              end
              CMD13: begin
                s.phase = PH_R2TAIL; r.tx_valid = 1'b1;
              end
              default: begin fin = 1'b1; fcode = ERR_TIMEOUT; end
            endcase
          end
        end
        PH_R7, PH_OCR: begin
          s.response_word = rw;
          s.byte_count = bc;
          if (bc < 10'd4) r.tx_valid = 1'b1;
          else if (st_i.phase == PH_R7) begin
            if (rw[11:8] != 4'd1 || rw[7:0] != 8'hAA) begin
              fin = 1'b1; fcode = ERR_BAD_R7;
            end else begin
              s.acmd_count = '0; do_cmd = 1'b1; ncmd = CMD55;
            end
          end else begin
            fin = 1'b1;
            fcode = rw[30] ? ERR_NONE : ERR_STD_CAP;
          end
        end
        PH_TOKEN: begin
          if (v == 8'hFE) begin
            s.phase = PH_RDATA; s.byte_count = '0; r.tx_valid = 1'b1;
          end else begin
            s.retry_count = rc;
            if (rc >= max_retries_i) begin fin = 1'b1; fcode = ERR_TIMEOUT; end
            else r.tx_valid = 1'b1;
          end
        end
        PH_RDATA: begin
          r.read_valid = 1'b1;
          r.read_byte = v;
          s.byte_count = bc;
          if (st_i.byte_count == 10'(BlockBytes - 1)) begin
            r.read_last = 1'b1; s.phase = PH_RCRC; s.byte_count = '0;
          end
          r.tx_valid = 1'b1;
        end
        PH_RCRC: begin
          s.byte_count = bc;
          if (bc < 10'd2) r.tx_valid = 1'b1;
          else fin = 1'b1;
        end
        PH_WTOKEN: begin
          s.phase = PH_WWANT; s.byte_count = '0; r.want_write_byte = 1'b1;
        end
        PH_WDATA: begin
          s.byte_count = bc;
          if (st_i.byte_count != 10'(BlockBytes - 1)) begin
            s.phase = PH_WWANT; r.want_write_byte = 1'b1;
          end else begin
            s.phase = PH_DRESP; s.retry_count = '0; r.tx_valid = 1'b1;
          end
        end
        PH_DRESP: begin
          if (v[4]) begin
            s.retry_count = rc;
            if (rc >= max_retries_i) begin fin = 1'b1; fcode = ERR_TIMEOUT; end
            else r.tx_valid = 1'b1;
          end else begin
            s.response_word = {24'd0, v}; s.phase = PH_BUSY; r.tx_valid = 1'b1;
          end
        end
        PH_BUSY: begin
          if (v != 8'hFF) r.tx_valid = 1'b1;
          else if (st_i.response_word[3:1] == 3'b010) fin = 1'b1;
          else begin do_cmd = 1'b1; ncmd = CMD13; end
        end
        PH_R2TAIL: begin fin = 1'b1; fcode = ERR_WREJECT; end
        default: ;
      endcase
    end else if (req_i.req_type == REQ_WDATA && st_i.phase == PH_WWANT) begin
      s.phase = PH_WDATA;
      r.tx_valid = 1'b1;
      r.tx_byte = v;
    end

    // Launch a command frame: first byte goes out now
    if (do_cmd) begin
      s.command_frame = {2'b01, ncmd, narg, ncrc};
      s.byte_count = '0;
      s.phase = PH_CMD;
      r.tx_valid = 1'b1;
      r.tx_byte = {2'b01, ncmd};
    end

    // End the operation
    if (fin) begin
      s.phase = PH_IDLE;
      r.tx_valid = 1'b0;
      r.tx_byte = 8'hFF;
      if (fcode != ERR_NONE) begin
        r.error = 1'b1; r.error_code = fcode;
      end else r.done_res = 1'b1;
    end

    r.busy_res = (s.phase != PH_IDLE);
    r.chip_select_active = (s.phase != PH_IDLE) && (s.phase != PH_PWR);
    st_o = s;
    res_o = r;
  end

endmodule
